FILE: sv/bmao_pkg.sv
// Shared constants and types for the byte memory with atomic operations.
package bmao_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int BADDR_W   = 16;
    localparam int DATA_W    = 64;
    localparam int CNT_W     = 4;

    typedef enum logic [3:0] {
        AMO_NONE = 4'd0,
        AMO_LRSC = 4'd1,
        AMO_SWAP = 4'd2,
        AMO_ADD  = 4'd3,
        AMO_XOR  = 4'd4,
        AMO_AND  = 4'd5,
        AMO_OR   = 4'd6,
        AMO_MIN  = 4'd7,
        AMO_MAX  = 4'd8,
        AMO_MINU = 4'd9,
        AMO_MAXU = 4'd10
    } amo_op_t;

    localparam logic [1:0] SIZE_BYTE   = 2'd0;
    localparam logic [1:0] SIZE_HALF   = 2'd1;
    localparam logic [1:0] SIZE_WORD   = 2'd2;
    localparam logic [1:0] SIZE_DOUBLE = 2'd3;

endpackage

FILE: sv/bmao_ram.sv
// Generic single-port RAM with registered read data.
module bmao_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

FILE: sv/bmao_alu.sv
// Atomic combine unit: computes the value stored by a write transaction.
module bmao_alu (
    input  logic [1:0]                 size_log2,
    input  logic [3:0]                 amo_op,
    input  logic [bmao_pkg::DATA_W-1:0] old_value,
    input  logic [bmao_pkg::DATA_W-1:0] operand,
    output logic [bmao_pkg::DATA_W-1:0] new_value
);

    import bmao_pkg::*;

    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] sbit;
    logic [DATA_W-1:0] o;
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] sum;
    logic              d_lt_u;
    logic              d_gt_u;
    logic              d_lt_s;
    logic              d_gt_s;
    logic [DATA_W-1:0] combined;

    always_comb
    begin
        if (size_log2 == SIZE_DOUBLE)
        begin
            mask = '1;
            sbit = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            mask = {{(DATA_W/2){1'b0}}, {(DATA_W/2){1'b1}}};
            sbit = {{(DATA_W/2){1'b0}}, 1'b1, {(DATA_W/2-1){1'b0}}};
        end
        o      = old_value & mask;
        d      = operand & mask;
        sum    = (o + d) & mask;
        d_lt_u = d < o;
        d_gt_u = d > o;
        d_lt_s = (d ^ sbit) < (o ^ sbit);
        d_gt_s = (d ^ sbit) > (o ^ sbit);
        case (amo_op_t'(amo_op))
            AMO_NONE, AMO_LRSC, AMO_SWAP: combined = d;
            AMO_ADD:  combined = sum;
            AMO_XOR:  combined = o ^ d;
            AMO_AND:  combined = o & d;
            AMO_OR:   combined = o | d;
            AMO_MIN:  combined = d_lt_s ? d : o;
            AMO_MAX:  combined = d_gt_s ? d : o;
            AMO_MINU: combined = d_lt_u ? d : o;
            AMO_MAXU: combined = d_gt_u ? d : o;
            default:  combined = o;
        endcase
        if (size_log2 inside {SIZE_WORD, SIZE_DOUBLE})
        begin
            new_value = combined;
        end
        else
        begin
            new_value = operand;
        end
    end

endmodule

FILE: sv/byte_memory_with_atomic_ops_core.sv
// Top level: byte-wide memory with read, store and atomic transactions.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  request  | start / busy        | mode, byte_address, size_log2, amo_op, write_data
//  result   | done (1-cycle pulse)| old_value
//
//  A read fetches n bytes in order, then pulses done; a write reads the
//  old bytes, computes the new value in S_CALC and writes n bytes (no read
//  for store-conditional). The single byte-wide memory port reads or
//  writes one byte a cycle. After reset the memory is zeroed one byte a
//  cycle while busy. done pulses for one cycle and cannot be held off.
module byte_memory_with_atomic_ops_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic [bmao_pkg::BADDR_W-1:0]  byte_address,
    input  logic [1:0]                    size_log2,
    input  logic [3:0]                    amo_op,
    input  logic [bmao_pkg::DATA_W-1:0]   write_data,
    output logic                          done,
    output logic [bmao_pkg::DATA_W-1:0]   old_value
);

    import bmao_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CALC,
        S_WRITE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [1:0]         size_reg, size_next;
    logic [3:0]         op_reg, op_next;
    logic               mode_reg, mode_next;
    logic [DATA_W-1:0]  data_reg, data_next;
    logic [DATA_W-1:0]  old_reg, old_next;
    logic [DATA_W-1:0]  new_reg, new_next;
    logic               done_reg, done_next;

    logic [CNT_W-1:0]   nbytes;
    logic [2:0]         lane;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [7:0]         ram_wdata;
    logic [7:0]         ram_rdata;
    logic [DATA_W-1:0]  alu_value;

    bmao_ram #(
        .WIDTH(8),
        .DEPTH(MEM_BYTES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    bmao_alu u_alu (
        .size_log2(size_reg),
        .amo_op   (op_reg),
        .old_value(old_reg),
        .operand  (data_reg),
        .new_value(alu_value)
    );

    assign nbytes    = CNT_W'(1) << size_reg;
    assign lane      = 3'(cnt_reg - CNT_W'(1));
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign old_value = old_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        clr_next   = clr_reg;
        addr_next  = addr_reg;
        size_next  = size_reg;
        op_next    = op_reg;
        mode_next  = mode_reg;
        data_next  = data_reg;
        old_next   = old_reg;
        new_next   = new_reg;
        done_next  = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = addr_reg + ADDR_W'(cnt_reg);
        ram_wdata  = new_reg[{cnt_reg[2:0], 3'b000} +: 8];
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    addr_next = ADDR_W'(byte_address);
                    size_next = size_log2;
                    op_next   = amo_op;
                    mode_next = mode;
                    data_next = write_data;
                    old_next  = '0;
                    cnt_next  = '0;
                    if (mode && (amo_op_t'(amo_op) == AMO_LRSC))
                    begin
                        state_next = S_CALC;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                if (cnt_reg != '0)
                begin
                    old_next[{lane, 3'b000} +: 8] = ram_rdata;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == nbytes)
                begin
                    cnt_next = '0;
                    if (mode_reg)
                    begin
                        state_next = S_CALC;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_CALC:
            begin
                new_next   = alu_value;
                cnt_next   = '0;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == nbytes - CNT_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        size_reg <= size_next;
        op_reg   <= op_next;
        mode_reg <= mode_next;
        data_reg <= data_next;
        old_reg  <= old_next;
        new_reg  <= new_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a transaction in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> busy)
        else $error("memory write while idle");

endmodule
